/* sv/sbr_pkg.sv */
`default_nettype none

package sbr_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef struct packed {
    logic [31:0] stream_index;
    logic [7:0]  data_byte;
    logic        has_byte;
    logic        segment_last;
    logic        eof_flag;
    logic [6:0]  output_space;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       stream_ended;
    logic [6:0] pending_count;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

  // (base + ofs) mod CAPACITY, for base < CAPACITY and ofs <= CAPACITY
  function automatic logic [IDX_W-1:0] slot_wrap(input logic [IDX_W-1:0] base,
                                                 input logic [CNT_W-1:0] ofs);
    logic [CNT_W:0] sum;
    logic [CNT_W:0] red;
    sum = (CNT_W+1)'(base) + (CNT_W+1)'(ofs);
    red = sum - (CNT_W+1)'(CAPACITY);
    if (sum >= (CNT_W+1)'(CAPACITY)) begin
      return red[IDX_W-1:0];
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* sv/stream_byte_reassembler_core.sv */
// Item without segment_last: taken with no result; such items go one per cycle while busy is low.
// Item with segment_last: a scan of the valid marks counts the bytes to flush (n = bytes flushed),
// then the byte store is read one slot per cycle; read data and strobe are registered, so results
// appear one per cycle; busy stays high through scan and read. An empty flush gives one status-only result.
// Results are strobed for one cycle; the receiver cannot stall.
// Synchronous reset clears valid marks, window and counters; the byte store is not cleared.
`default_nettype none

module stream_byte_reassembler_core
  import sbr_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    start,
  output logic         busy,
  input  wire item_t   item,
  output logic         result_strobe,
  output result_t      result
);

  logic [7:0]          mem [CAPACITY];
  logic [7:0]          rd_data;

  state_t              state, state_next;
  logic [CAPACITY-1:0] valid;
  logic [31:0]         next_index;
  logic [IDX_W-1:0]    base;
  logic [CNT_W-1:0]    unassembled;
  logic                eof_seen;
  logic                ended;
  logic [CNT_W-1:0]    k;
  logic [CNT_W-1:0]    j;
  logic [CNT_W-1:0]    lim;
  logic                out_bv;
  logic                out_last;

  logic                accept;
  logic [31:0]         ofs;
  logic                in_win;
  logic [IDX_W-1:0]    wr_slot;
  logic                wr_en;
  logic [IDX_W-1:0]    scan_slot;
  logic [IDX_W-1:0]    emit_slot;
  logic                scan_hit;
  logic                scan_end;
  logic                issue;
  logic [CNT_W-1:0]    j_inc;
  logic [CNT_W-1:0]    pend_after;

  assign busy       = (state != ST_IDLE);
  assign accept     = start && !busy;
  assign ofs        = item.stream_index - next_index;
  assign in_win     = (ofs < 32'(CAPACITY));
  assign wr_slot    = slot_wrap(base, ofs[CNT_W-1:0]);
  assign wr_en      = accept && item.has_byte && in_win;
  assign scan_slot  = slot_wrap(base, k);
  assign emit_slot  = slot_wrap(base, j);
  assign scan_hit   = (k < lim) && valid[scan_slot];
  assign j_inc      = j + CNT_W'(1);
  assign pend_after = unassembled - k;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    scan_end   = 1'b0;
    issue      = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept && item.segment_last) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!scan_hit) begin
          scan_end   = 1'b1;
          state_next = (k == '0) ? ST_IDLE : ST_EMIT;
        end
      end
      ST_EMIT: begin
        issue = 1'b1;
        if (j_inc == k) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid         <= '0;
      next_index    <= '0;
      base          <= '0;
      unassembled   <= '0;
      eof_seen      <= 1'b0;
      ended         <= 1'b0;
      k             <= '0;
      j             <= '0;
      lim           <= '0;
      result_strobe <= 1'b0;
      out_bv        <= 1'b0;
      out_last      <= 1'b0;
    end else begin
      result_strobe <= 1'b0;
      if (wr_en) begin
        valid[wr_slot] <= 1'b1;
        if (!valid[wr_slot]) begin
          unassembled <= unassembled + CNT_W'(1);
        end
      end
      if (accept && item.segment_last) begin
        k   <= '0;
        lim <= (item.output_space > 7'(CAPACITY)) ? CNT_W'(CAPACITY)
                                                  : item.output_space[CNT_W-1:0];
        if (item.eof_flag) begin
          eof_seen <= 1'b1;
        end
      end
      if (state == ST_SCAN && scan_hit) begin
        k <= k + CNT_W'(1);
      end
      if (scan_end) begin
        unassembled <= pend_after;
        ended       <= eof_seen && (pend_after == '0);
        j           <= '0;
        if (k == '0) begin
          result_strobe <= 1'b1;
          out_bv        <= 1'b0;
          out_last      <= 1'b1;
        end
      end
      if (issue) begin
        valid[emit_slot] <= 1'b0;
        j                <= j_inc;
        result_strobe    <= 1'b1;
        out_bv           <= 1'b1;
        out_last         <= (j_inc == k);
        if (j_inc == k) begin
          base       <= slot_wrap(base, k);
          next_index <= next_index + 32'(k);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_slot] <= item.data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data <= mem[emit_slot];
    end
  end

  assign result.out_byte      = out_bv ? rd_data : 8'd0;
  assign result.byte_valid    = out_bv;
  assign result.run_last      = out_last;
  assign result.stream_ended  = ended;
  assign result.pending_count = 7'(unassembled);

`ifndef SYNTHESIS
  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> ($countones(valid) == 32'(unassembled)))
    else $error("valid marks disagree with pending count");

  a_status_is_last: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && !out_bv) |-> out_last)
    else $error("status-only result not marked last");

  a_gap_after_run: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && out_last) |=> !result_strobe)
    else $error("result right after end of run");

  a_flush_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && item.segment_last) |=> busy)
    else $error("flush did not raise busy");
`endif

endmodule

`default_nettype wire

/* tb/sv/stream_byte_reassembler_core_test.sv */
`default_nettype none

module stream_byte_reassembler_core_test;
  import sbr_pkg::*;

  localparam int STALL_LIMIT = 1000;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  logic    busy;
  item_t   item = '0;
  logic    result_strobe;
  result_t result;

  stream_byte_reassembler_core uut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .item          (item),
    .result_strobe (result_strobe),
    .result        (result)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [7:0]  seg_store [CAPACITY];
  bit          seg_marks [CAPACITY];
  logic [31:0] next_index = '0;
  int          window_base = 0;
  int          unassembled = 0;
  bit          eof_seen = 1'b0;

  result_t expected_results [$];

  int  errors = 0;
  int  items_sent = 0;
  int  flushes = 0;
  int  bytes_delivered = 0;
  int  result_transfers = 0;
  int  stall_cycles = 0;
  int  full_windows = 0;
  bit  burst = 1'b0;

  initial begin
    for (int i = 0; i < CAPACITY; i++) begin
      seg_marks[i] = 1'b0;
    end
  end

  task automatic reassemble_item(input item_t it);
    logic [31:0] ofs;
    int          slot;
    int          room;
    int          n;
    bit          ended;
    result_t     r;
    logic [7:0]  run_bytes [$];
    if (it.has_byte) begin
      ofs = it.stream_index - next_index;
      if (ofs < CAPACITY) begin
        slot = (window_base + int'(ofs)) % CAPACITY;
        seg_store[slot] = it.data_byte;
        if (!seg_marks[slot]) begin
          seg_marks[slot] = 1'b1;
          unassembled++;
        end
      end
    end
    if (!it.segment_last) begin
      return;
    end
    flushes++;
    room = (int'(it.output_space) > CAPACITY) ? CAPACITY : int'(it.output_space);
    n = 0;
    while (n < room && seg_marks[(window_base + n) % CAPACITY]) begin
      slot = (window_base + n) % CAPACITY;
      run_bytes.push_back(seg_store[slot]);
      seg_marks[slot] = 1'b0;
      n++;
    end
    unassembled -= n;
    next_index = next_index + 32'(n);
    window_base = (window_base + n) % CAPACITY;
    bytes_delivered += n;
    if (it.eof_flag) begin
      eof_seen = 1'b1;
    end
    ended = eof_seen && (unassembled == 0);
    if (n == 0) begin
      r.out_byte      = 8'h00;
      r.byte_valid    = 1'b0;
      r.run_last      = 1'b1;
      r.stream_ended  = ended;
      r.pending_count = 7'(unassembled);
      expected_results.push_back(r);
    end else begin
      for (int k = 0; k < n; k++) begin
        r.out_byte      = run_bytes[k];
        r.byte_valid    = 1'b1;
        r.run_last      = (k == n - 1);
        r.stream_ended  = ended;
        r.pending_count = 7'(unassembled);
        expected_results.push_back(r);
      end
    end
  endtask

  function automatic item_t mk_item(input logic [31:0] idx, input logic [7:0] data,
                                    input bit has, input bit last, input bit eof,
                                    input logic [6:0] space);
    item_t it;
    it.stream_index = idx;
    it.data_byte    = data;
    it.has_byte     = has;
    it.segment_last = last;
    it.eof_flag     = eof;
    it.output_space = space;
    return it;
  endfunction

  function automatic int draw_gap();
    return burst ? 0 : $urandom_range(0, 18);
  endfunction

  // holds start high across back-to-back transfers
  task automatic send_item(input item_t it, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy);
    reassemble_item(it);
    items_sent++;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && result_strobe) begin
      result_transfers++;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result transfer: expected none, actual %h", $time, result);
        errors++;
      end else begin
        want = expected_results.pop_front();
        check_field("out_byte", 32'(want.out_byte), 32'(result.out_byte));
        check_field("byte_valid", 32'(want.byte_valid), 32'(result.byte_valid));
        check_field("run_last", 32'(want.run_last), 32'(result.run_last));
        check_field("stream_ended", 32'(want.stream_ended), 32'(result.stream_ended));
        check_field("pending_count", 32'(want.pending_count), 32'(result.pending_count));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || result_strobe) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic test_empty_segments();
    send_item(mk_item(32'h0, 8'h00, 1'b0, 1'b0, 1'b0, 7'd0), draw_gap());
    send_item(mk_item(32'h5, 8'hFF, 1'b0, 1'b1, 1'b0, 7'd64), draw_gap());
  endtask

  task automatic test_in_order_run();
    logic [31:0] n;
    n = next_index;
    send_item(mk_item(n, 8'hA5, 1'b1, 1'b0, 1'b0, 7'd0), draw_gap());
    send_item(mk_item(n + 1, 8'h5A, 1'b1, 1'b0, 1'b0, 7'd0), draw_gap());
    send_item(mk_item(n + 2, 8'hFF, 1'b1, 1'b1, 1'b0, 7'd127), draw_gap());
  endtask

  task automatic test_gap_fill_and_overwrite();
    logic [31:0] n;
    n = next_index;
    send_item(mk_item(n + 2, 8'h11, 1'b1, 1'b0, 1'b0, 7'd0), draw_gap());
    send_item(mk_item(n + 1, 8'h22, 1'b1, 1'b0, 1'b0, 7'd0), draw_gap());
    send_item(mk_item(n + 1, 8'h33, 1'b1, 1'b0, 1'b0, 7'd0), draw_gap());
    send_item(mk_item(n, 8'h44, 1'b1, 1'b1, 1'b0, 7'd2), draw_gap());
    send_item(mk_item(n, 8'h00, 1'b0, 1'b1, 1'b0, 7'd0), draw_gap());
    send_item(mk_item(n, 8'h00, 1'b0, 1'b1, 1'b0, 7'd64), draw_gap());
  endtask

  task automatic test_window_bounds();
    logic [31:0] n;
    n = next_index;
    send_item(mk_item(n + 63, 8'h80, 1'b1, 1'b0, 1'b0, 7'd0), draw_gap());
    send_item(mk_item(n + 64, 8'h01, 1'b1, 1'b0, 1'b0, 7'd0), draw_gap());
    send_item(mk_item(n - 1, 8'h02, 1'b1, 1'b0, 1'b0, 7'd0), draw_gap());
    send_item(mk_item(32'hFFFF_FFFF, 8'h03, 1'b1, 1'b0, 1'b1, 7'd127), draw_gap());
    send_item(mk_item(n, 8'h7F, 1'b1, 1'b1, 1'b0, 7'd64), draw_gap());
  endtask

  task automatic test_end_of_stream();
    logic [31:0] n;
    n = next_index;
    send_item(mk_item(n, 8'hC3, 1'b1, 1'b0, 1'b1, 7'd64), draw_gap());
    send_item(mk_item(n + 2, 8'h3C, 1'b1, 1'b1, 1'b1, 7'd64), draw_gap());
    send_item(mk_item(n + 1, 8'h96, 1'b1, 1'b1, 1'b0, 7'd1), draw_gap());
    send_item(mk_item(n, 8'h00, 1'b0, 1'b1, 1'b0, 7'd64), draw_gap());
  endtask

  task automatic random_segment();
    int          kind;
    int          len;
    int          first;
    int          pick;
    logic [6:0]  space;
    logic [31:0] base;
    item_t       it;
    burst = ($urandom_range(0, 3) == 0);
    kind  = $urandom_range(0, 19);
    base  = next_index;
    if (kind < 3) begin
      it.stream_index = $urandom;
      it.data_byte    = 8'($urandom);
      it.has_byte     = 1'($urandom);
      it.segment_last = 1'($urandom);
      it.eof_flag     = 1'($urandom);
      it.output_space = 7'($urandom);
      send_item(it, draw_gap());
      return;
    end
    if (kind == 3) begin
      first = CAPACITY + $urandom_range(0, 200);
      len   = $urandom_range(1, 3);
    end else if (kind == 4 && full_windows < 2 && items_sent < 180) begin
      full_windows++;
      first = 0;
      len   = CAPACITY;
    end else begin
      first = ($urandom_range(0, 4) == 0) ? -$urandom_range(1, 3) : $urandom_range(0, 6);
      len   = $urandom_range(1, 10);
    end
    pick = $urandom_range(0, 9);
    if (len == CAPACITY) begin
      space = $urandom_range(0, 1) ? 7'd0 : 7'($urandom_range(64, 127));
    end else if (pick == 0) begin
      space = 7'd0;
    end else if (pick == 1) begin
      space = 7'($urandom_range(65, 127));
    end else begin
      space = 7'($urandom_range(1, 64));
    end
    for (int k = 0; k < len; k++) begin
      it.stream_index = base + 32'(first + k);
      it.data_byte    = 8'($urandom);
      it.has_byte     = 1'b1;
      it.segment_last = (k == len - 1);
      if (it.segment_last) begin
        it.eof_flag     = ($urandom_range(0, 9) == 0);
        it.output_space = space;
        if ($urandom_range(0, 7) == 0) begin
          it.has_byte = 1'b0;
        end
      end else begin
        it.eof_flag     = 1'($urandom);
        it.output_space = 7'($urandom);
      end
      send_item(it, draw_gap());
    end
  endtask

  task automatic test_random_traffic();
    int target;
    target = items_sent + 250;
    while (items_sent < target) begin
      random_segment();
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_segments();
    test_in_order_run();
    test_gap_fill_and_overwrite();
    test_window_bounds();
    test_end_of_stream();
    test_random_traffic();
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (2 * CAPACITY + 8) @(posedge clk);
    $display("Sent %0d input transfers, %0d of them segment ends; %0d result transfers",
             items_sent, flushes, result_transfers);
    $display("carried %0d reassembled bytes, with window edges, overwrites and end of stream.",
             bytes_delivered);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* stream_byte_reassembler_core.f */
sv/sbr_pkg.sv
sv/stream_byte_reassembler_core.sv
tb/sv/stream_byte_reassembler_core_test.sv
